// File: hdl/kmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_pkg
// shared types, constants and helper functions of the kmp stream matcher
// ----------------------------------------------------------------------------
package kmp_pkg;

    // pattern geometry
    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_BYTES   = 16;
    localparam int PAT_W       = 8 * PAT_BYTES;
    localparam int LEN_FIELD_W = 5;

    // text position and result fields
    localparam int POS_W       = 32;

    // register port
    localparam int CFG_DATA_W  = 64;
    localparam int ADDR_W      = 5;
    localparam int REG_LSB     = 3;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QCNT_W-1:0] qcnt_t;

    typedef enum logic [1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } reg_index_t;

    typedef enum logic {
        ITEM_CONTINUE = 1'b0,
        ITEM_RESTART  = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_of_text;
    } in_item_t;

    typedef struct packed {
        logic                   match;
        logic [POS_W-1:0]       match_start;
        logic [LEN_FIELD_W-1:0] prefix_length;
    } out_item_t;

    typedef struct packed {
        logic [7:0] text_byte;
        item_kind_t kind;
    } q_item_t;

    typedef struct packed {
        logic [PAT_W-1:0]       pattern;
        logic [LEN_FIELD_W-1:0] length;
        logic                   rebuild;
        logic                   access;
    } cfg_t;

    typedef struct packed {
        logic table_ready;
    } eng_status_t;

    // pattern length in use, forced into 1..MAX_PATTERN
    function automatic len_t eff_len(input logic [LEN_FIELD_W-1:0] len_field);
        int n;
        n = int'(len_field);
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return len_t'(n);
    endfunction

    // pattern byte at an index, zero past the pattern registers
    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pattern,
                                            input idx_t idx);
        logic [7:0] b;
        b = '0;
        if (int'(idx) < PAT_BYTES) b = pattern[8*idx +: 8];
        return b;
    endfunction

endpackage
`default_nettype wire

// File: hdl/kmp_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_cfg_regs
// register bank on the apb-style port, flags a table rebuild after each write to a mapped register
// ----------------------------------------------------------------------------
module kmp_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [kmp_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [kmp_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [kmp_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output kmp_pkg::cfg_t                         cfg
);

    logic [63:0]                       pattern_low_reg;
    logic [63:0]                       pattern_high_reg;
    logic [kmp_pkg::LEN_FIELD_W-1:0]   pattern_length_reg;
    logic                              rebuild_reg;
    logic                              wr_en;
    kmp_pkg::reg_index_t               index;

    assign index  = kmp_pkg::reg_index_t'(paddr[kmp_pkg::ADDR_W-1:kmp_pkg::REG_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // rebuild flag comes out of reset set so the table is built once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= kmp_pkg::LEN_FIELD_W'(1);
            rebuild_reg        <= 1'b1;
        end else begin
            rebuild_reg <= 1'b0;
            if (wr_en) begin
                unique case (index)
                    kmp_pkg::REG_PATTERN_LOW: begin
                        pattern_low_reg <= pwdata[63:0];
                        rebuild_reg     <= 1'b1;
                    end
                    kmp_pkg::REG_PATTERN_HIGH: begin
                        pattern_high_reg <= pwdata[63:0];
                        rebuild_reg      <= 1'b1;
                    end
                    kmp_pkg::REG_PATTERN_LENGTH: begin
                        pattern_length_reg <= pwdata[kmp_pkg::LEN_FIELD_W-1:0];
                        rebuild_reg        <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (index)
            kmp_pkg::REG_PATTERN_LOW:    prdata = pattern_low_reg;
            kmp_pkg::REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            kmp_pkg::REG_PATTERN_LENGTH: prdata = kmp_pkg::CFG_DATA_W'(pattern_length_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.length  = pattern_length_reg;
    assign cfg.rebuild = rebuild_reg;
    assign cfg.access  = psel && pwrite;

endmodule
`default_nettype wire

// File: hdl/kmp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_front
// accepts text bytes, tags restarts and hands them to the request queue
// ----------------------------------------------------------------------------
module kmp_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire kmp_pkg::in_item_t s_data,
    input  wire logic             accept_en,
    input  wire logic             q_full,
    output logic                  q_push,
    output kmp_pkg::q_item_t      q_item
);

    logic             f_valid_reg;
    kmp_pkg::q_item_t f_item_reg;
    kmp_pkg::q_item_t f_item_next;
    logic             take;

    assign s_ready = accept_en && (!f_valid_reg || !q_full);
    assign take    = s_valid && s_ready;
    assign q_push  = f_valid_reg && !q_full;
    assign q_item  = f_item_reg;

    always_comb begin
        f_item_next.text_byte = s_data.text_byte;
        f_item_next.kind      = s_data.first_of_text ? kmp_pkg::ITEM_RESTART
                                                     : kmp_pkg::ITEM_CONTINUE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (take) begin
            f_valid_reg <= 1'b1;
        end else if (q_push) begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_item_reg <= f_item_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/kmp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_queue
// short fifo of requests between the front and the matching engine
// ----------------------------------------------------------------------------
module kmp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire kmp_pkg::q_item_t  push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   q_valid,
    output kmp_pkg::q_item_t       q_item
);

    kmp_pkg::q_item_t slot_reg [kmp_pkg::QUEUE_DEPTH];
    kmp_pkg::qptr_t   wr_ptr_reg;
    kmp_pkg::qptr_t   rd_ptr_reg;
    kmp_pkg::qcnt_t   count_reg;
    logic             do_push;
    logic             do_pop;

    localparam kmp_pkg::qptr_t LAST_SLOT = kmp_pkg::qptr_t'(kmp_pkg::QUEUE_DEPTH - 1);
    localparam kmp_pkg::qcnt_t FULL_CNT  = kmp_pkg::qcnt_t'(kmp_pkg::QUEUE_DEPTH);

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: hdl/kmp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_back
// builds the prefix table and runs the per-byte compare and fallback loop
// ----------------------------------------------------------------------------
module kmp_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire kmp_pkg::cfg_t        cfg,
    input  wire logic                 q_valid,
    input  wire kmp_pkg::q_item_t     q_item,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output kmp_pkg::out_item_t        m_data,
    output kmp_pkg::eng_status_t      status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_MATCH
    } state_t;

    state_t                     state_reg;
    kmp_pkg::len_t              tbl_reg [kmp_pkg::MAX_PATTERN];
    kmp_pkg::len_t              bi_reg;
    kmp_pkg::len_t              blen_reg;
    kmp_pkg::len_t              tail_reg;
    kmp_pkg::len_t              m_reg;
    logic [7:0]                 c_reg;
    logic [kmp_pkg::POS_W-1:0]  pos_reg;
    logic                       m_valid_reg;
    kmp_pkg::out_item_t         m_data_reg;

    kmp_pkg::len_t              n;
    kmp_pkg::idx_t              rd_addr;
    kmp_pkg::len_t              tbl_rd;
    logic [7:0]                 cmp_a;
    logic [7:0]                 cmp_b;
    logic                       eq;
    logic                       build_active;
    logic                       tbl_we;
    kmp_pkg::len_t              tbl_wdata;
    logic                       fallback;
    logic                       out_free;
    kmp_pkg::len_t              m_adv;
    logic                       hit;
    kmp_pkg::len_t              m_final;

    assign n            = kmp_pkg::eff_len(cfg.length);
    assign build_active = (state_reg == ST_BUILD) && (bi_reg < n);

    // one table read port and one comparator, shared by build and match
    assign rd_addr = (state_reg == ST_BUILD) ? kmp_pkg::idx_t'(blen_reg - 1'b1)
                                             : kmp_pkg::idx_t'(m_reg - 1'b1);
    assign tbl_rd  = tbl_reg[rd_addr];
    assign cmp_a   = (state_reg == ST_BUILD)
                   ? kmp_pkg::pat_byte(cfg.pattern, kmp_pkg::idx_t'(bi_reg)) : c_reg;
    assign cmp_b   = kmp_pkg::pat_byte(cfg.pattern, (state_reg == ST_BUILD)
                   ? kmp_pkg::idx_t'(blen_reg) : kmp_pkg::idx_t'(m_reg));
    assign eq      = (cmp_a == cmp_b);

    assign tbl_we    = build_active && (eq || (blen_reg == '0));
    assign tbl_wdata = eq ? blen_reg + 1'b1 : '0;

    assign fallback = (m_reg != '0) && !eq;
    assign out_free = !m_valid_reg || m_ready;
    assign m_adv    = eq ? m_reg + 1'b1 : m_reg;
    assign hit      = (m_adv == n);
    assign m_final  = hit ? tail_reg : m_adv;

    assign q_pop              = (state_reg == ST_IDLE) && !cfg.rebuild && q_valid;
    assign status.table_ready = (state_reg != ST_BUILD) && !cfg.rebuild;
    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_reg       <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg.rebuild) begin
                state_reg <= ST_BUILD;
                bi_reg    <= kmp_pkg::len_t'(1);
                blen_reg  <= '0;
                tail_reg  <= '0;
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        if (q_valid) begin
                            c_reg     <= q_item.text_byte;
                            state_reg <= ST_MATCH;
                            if (q_item.kind == kmp_pkg::ITEM_RESTART) begin
                                pos_reg <= '0;
                                m_reg   <= '0;
                            end else if (m_reg >= n) begin
                                m_reg <= '0;
                            end
                        end
                    end
                    ST_MATCH: begin
                        if (fallback) begin
                            m_reg <= tbl_rd;
                        end else if (out_free) begin
                            m_reg                    <= m_final;
                            pos_reg                  <= pos_reg + 1'b1;
                            m_valid_reg              <= 1'b1;
                            m_data_reg.match         <= hit;
                            m_data_reg.match_start   <= hit
                                ? pos_reg + 1'b1 - kmp_pkg::POS_W'(n) : '0;
                            m_data_reg.prefix_length <= kmp_pkg::LEN_FIELD_W'(m_adv);
                            state_reg                <= ST_IDLE;
                        end
                    end
                    ST_BUILD: begin
                        if (bi_reg >= n) begin
                            state_reg <= ST_IDLE;
                        end else if (eq) begin
                            blen_reg <= blen_reg + 1'b1;
                            bi_reg   <= bi_reg + 1'b1;
                        end else if (blen_reg != '0) begin
                            blen_reg <= tbl_rd;
                        end else begin
                            bi_reg <= bi_reg + 1'b1;
                        end
                        // fallback entry for the last pattern byte, kept at hand
                        if (tbl_we && (bi_reg == n - 1'b1)) begin
                            tail_reg <= tbl_wdata;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cfg.rebuild) begin
            tbl_reg[0] <= '0;
        end else if (tbl_we) begin
            tbl_reg[kmp_pkg::idx_t'(bi_reg)] <= tbl_wdata;
        end
    end

endmodule
`default_nettype wire

// File: hdl/kmp_stream_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// path: front register, request queue, engine idle and match states, output register
//   each fallback step through the prefix table keeps the engine in the match state
// pacing: the engine takes a new text byte only once the last leaves the match state
// table build: after reset and after every write to a pattern or length register, on
//   the single shared compare unit, with s_ready low while the table is rebuilt
// reset: synchronous active-low aresetn clears control state and matching state
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// streaming knuth-morris-pratt matcher: finds every occurrence of a pattern of
// up to sixteen bytes in a byte stream, one result per text byte
// ----------------------------------------------------------------------------
module kmp_stream_matcher (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // text byte requests
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire kmp_pkg::in_item_t              s_data,
    // match results
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output kmp_pkg::out_item_t                  m_data,
    // register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [kmp_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [kmp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [kmp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);

    kmp_pkg::cfg_t        cfg;
    kmp_pkg::eng_status_t status;
    logic                 accept_en;
    logic                 q_full;
    logic                 q_push;
    kmp_pkg::q_item_t     push_item;
    logic                 q_valid;
    logic                 q_pop;
    kmp_pkg::q_item_t     q_item;

    // pattern registers; any write to a mapped register asks the engine for a table rebuild
    kmp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // requests are held off while the table is stale or a write is under way
    assign accept_en = status.table_ready && !cfg.access;

    // front: input register, tags restart requests
    kmp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .accept_en (accept_en),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    // decoupling queue, lets the front keep taking bytes during fallbacks
    kmp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // back: table builder and matching loop with the output register
    kmp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .status  (status)
    );

endmodule
`default_nettype wire

// File: hdl/kmp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_checker
// port-level checks of the matcher, bound to the top level
// ----------------------------------------------------------------------------
module kmp_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire kmp_pkg::out_item_t         m_data,
    input wire logic                       psel,
    input wire logic                       penable,
    input wire logic                       pwrite,
    input wire logic [kmp_pkg::ADDR_W-1:0] paddr,
    input wire logic                       pready
);

    // a result waiting for the sink holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no request taken while a register write is in progress
    a_no_accept_in_write: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && pwrite |-> !s_ready)
        else $error("request accepted during register write");

    // a completed write to a pattern register stales the table, so requests stop next cycle
    a_rebuild_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite
        && (paddr[kmp_pkg::ADDR_W-1:kmp_pkg::REG_LSB] <= kmp_pkg::REG_PATTERN_LENGTH)
        |=> !s_ready)
        else $error("request accepted before table rebuild");

    // a result only reports a match with a non-zero length
    a_match_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.match |-> m_data.prefix_length != '0)
        else $error("match reported with empty prefix");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("register port not ready");

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pready  (pready)
);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the kmp stream matcher: the pattern registers are
// programmed over the register port, text byte requests are streamed in with
// random gaps and result stalls, and every result is checked field by field
// against a local knuth-morris-pratt predictor
// ----------------------------------------------------------------------------
module tb_top;
    import kmp_pkg::*;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 4;
    // base latency plus the longest fallback chain, with margin
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 130;
    // an address one past the register list, writes to it are ignored
    localparam int unsigned UNMAPPED_REG  = 3;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_W-1:0]     paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // text byte requests still to be offered, and results still owed
    in_item_t  text_queue[$];
    out_item_t owed_results[$];

    // percentage of cycles on which each side holds back
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    // matcher model: its own copy of the registers, failure table and state
    logic [63:0] pat_lo_q;
    logic [63:0] pat_hi_q;
    logic [4:0]  pat_len_q;
    logic [4:0]  fail_tbl [MAX_PATTERN];
    logic [4:0]  cur_len;
    logic [31:0] text_pos;

    kmp_stream_matcher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // matcher model
    // ------------------------------------------------------------------------

    // length field in use: zero reads as one, anything past the maximum saturates
    function automatic int unsigned pattern_len();
        int unsigned n;
        n = pat_len_q;
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [7:0] pattern_at(input int unsigned k);
        if (k < 8) return pat_lo_q[8*k +: 8];
        if (k < 16) return pat_hi_q[8*(k-8) +: 8];
        return 8'h00;
    endfunction

    // longest proper prefix that is also a suffix, for each pattern prefix
    function automatic void rebuild_fail_table();
        int unsigned n;
        int unsigned i;
        int unsigned k;
        n = pattern_len();
        i = 1;
        k = 0;
        for (int j = 0; j < MAX_PATTERN; j++) fail_tbl[j] = '0;
        while (i < n) begin
            if (pattern_at(i) == pattern_at(k)) begin
                k++;
                fail_tbl[i] = 5'(k);
                i++;
            end else if (k > 0) begin
                k = fail_tbl[k-1];
            end else begin
                fail_tbl[i] = '0;
                i++;
            end
        end
    endfunction

    // one text byte through the matcher, updating the matched length and position
    function automatic out_item_t predict_result(input in_item_t req);
        out_item_t   res;
        int unsigned n;
        int unsigned m;
        res = '0;
        n = pattern_len();
        if (req.first_of_text) begin
            text_pos = '0;
            cur_len  = '0;
        end
        m = cur_len;
        // a length left over from a longer pattern starts afresh
        if (m >= n) m = 0;
        while (m > 0 && req.text_byte != pattern_at(m)) m = fail_tbl[m-1];
        if (req.text_byte == pattern_at(m)) m++;
        res.prefix_length = 5'(m);
        if (m == n) begin
            // full occurrence: carry on from the table so overlaps are found
            res.match       = 1'b1;
            res.match_start = text_pos + 32'd1 - 32'(n);
            m = fail_tbl[n-1];
        end
        cur_len  = 5'(m);
        text_pos = text_pos + 32'd1;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: offers queued text bytes, holding valid until accepted
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // accepted request: the model works out the result it owes
            if (s_valid && s_ready) owed_results.push_back(predict_result(s_data));
            // slot free when nothing is pending or the pending one just went
            if (!s_valid || s_ready) begin
                if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= text_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: each accepted result against the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $error("result with none owed: match %0d start %0d prefix %0d",
                       m_data.match, m_data.match_start, m_data.prefix_length);
                error_count++;
            end else begin
                want = owed_results.pop_front();
                if (m_data.match !== want.match) begin
                    $error("match: expected %0d, got %0d", want.match, m_data.match);
                    error_count++;
                end
                if (m_data.match_start !== want.match_start) begin
                    $error("match_start: expected %0d, got %0d",
                           want.match_start, m_data.match_start);
                    error_count++;
                end
                if (m_data.prefix_length !== want.prefix_length) begin
                    $error("prefix_length: expected %0d, got %0d",
                           want.prefix_length, m_data.prefix_length);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // register port and stimulus helpers
    // ------------------------------------------------------------------------

    // setup cycle then access cycle; the register takes the value in the access cycle
    task automatic write_reg(input int unsigned idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << REG_LSB);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    pat_lo_q  = value;
            REG_PATTERN_HIGH:   pat_hi_q  = value;
            REG_PATTERN_LENGTH: pat_len_q = value[4:0];
            default: ;
        endcase
        rebuild_fail_table();
    endtask

    // until every request is taken and every result back, then let it settle;
    // checked between edges so the driver's updates have all landed
    task automatic await_idle();
        while (text_queue.size() != 0 || s_valid || owed_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic restart);
        text_queue.push_back(in_item_t'{text_byte: b, first_of_text: restart});
    endtask

    // mostly pattern prefixes (whole ones give matches), with alphabet filler,
    // stray bytes and the odd restart breaking sequences up
    task automatic queue_random_text(input int unsigned count,
                                     input logic [7:0] sym_a, input logic [7:0] sym_b);
        int unsigned made;
        int unsigned k;
        int unsigned r;
        made = 0;
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 65) begin
                k = $urandom_range(pattern_len(), 1);
                for (int j = 0; j < k; j++) push_byte(pattern_at(j), $urandom_range(99) < 2);
                made += k;
            end else if (r < 85) begin
                push_byte($urandom_range(1) ? sym_a : sym_b, $urandom_range(99) < 2);
                made++;
            end else begin
                push_byte(8'($urandom), $urandom_range(99) < 2);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len_field;

        // model starts in the reset state: pattern of one zero byte
        pat_lo_q  = '0;
        pat_hi_q  = '0;
        pat_len_q = 5'd1;
        cur_len   = '0;
        text_pos  = '0;
        rebuild_fail_table();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset pattern, light idling on both sides
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        await_idle();

        // overlapping occurrences, a restart part-way through, a fallback
        write_reg(REG_PATTERN_LOW, 64'hFFFF_FFFF_4241_4241);
        write_reg(REG_PATTERN_LENGTH, 64'd4);
        push_byte("A", 1'b1);
        push_byte("B", 1'b0);
        push_byte("A", 1'b0);
        push_byte("B", 1'b1);
        push_byte("A", 1'b0);
        push_byte("B", 1'b0);
        push_byte("A", 1'b0);
        push_byte("B", 1'b0);
        push_byte("A", 1'b0);
        push_byte("B", 1'b0);
        push_byte("A", 1'b0);
        push_byte("C", 1'b0);
        await_idle();

        // zero length field behaves as length one
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        await_idle();

        // a write past the register list changes nothing
        write_reg(UNMAPPED_REG, '1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7E, 1'b0);
        await_idle();

        // random phases, cycling through the idling modes
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                sym_a = 8'hFF;
                sym_b = 8'h00;
            end else begin
                sym_a = 8'($urandom);
                sym_b = 8'($urandom);
            end
            for (int j = 0; j < 8; j++) begin
                lo[8*j +: 8] = $urandom_range(1) ? sym_a : sym_b;
                hi[8*j +: 8] = $urandom_range(1) ? sym_a : sym_b;
            end
            // full length, a saturating field, zero, then mostly short patterns
            case (p)
                0:       len_field = 5'd16;
                1:       len_field = 5'd31;
                2:       len_field = 5'd0;
                3:       len_field = 5'($urandom_range(16, 1));
                default: len_field = 5'($urandom_range(6, 1));
            endcase
            write_reg(REG_PATTERN_LOW, lo);
            write_reg(REG_PATTERN_HIGH, hi);
            write_reg(REG_PATTERN_LENGTH, 64'(len_field));

            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            queue_random_text(PHASE_ITEMS, sym_a, sym_b);
            await_idle();
        end

        if (error_count == 0 && owed_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
